/* src/htq_pkg.sv */
// Shared types and constants for the heightmap triangle height query block.
`default_nettype none

package htq_pkg;

    localparam int DIV_STEPS = 24;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    typedef enum logic [1:0] {
        CFG_GRID_SPACING = 2'd0,
        CFG_HEIGHT_GAIN  = 2'd1,
        CFG_MAP_COLUMNS  = 2'd2,
        CFG_MAP_ROWS     = 2'd3
    } cfg_index_t;

    typedef enum logic [1:0] {
        SEL_Y0 = 2'd0,
        SEL_YM = 2'd1,
        SEL_Y2 = 2'd2
    } sample_sel_t;

    typedef struct packed {
        logic              op;
        logic [15:0]       sample_index;
        logic [7:0]        sample_value;
        logic signed [23:0] pos_x;
        logic signed [23:0] pos_z;
    } query_t;

    typedef struct packed {
        logic [23:0] height;
        logic        upper_triangle;
    } result_t;

    typedef struct packed {
        logic        write_sample;
        logic        capture;
        logic        div_start;
        logic        div_frac;
        logic        axis_latch;
        logic        frac_latch;
        logic        base0_latch;
        logic        base1_latch;
        logic        rd_en;
        sample_sel_t rd_sel;
        logic        mac_en;
        logic        mac_first;
        sample_sel_t mac_sel;
        logic        scale;
        logic        out_load;
    } htq_cmd_t;

    typedef struct packed {
        logic div_busy;
    } htq_status_t;

endpackage

`default_nettype wire

/* src/htq_div.sv */
// Restoring divider that produces one quotient bit per cycle.
`default_nettype none

module htq_div (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [15:0] init_rem,
    input  wire logic [23:0] dividend,
    input  wire logic [15:0] divisor,
    output logic             busy,
    output logic [23:0]      quotient,
    output logic [15:0]      remainder
);
    import htq_pkg::*;

    logic [15:0]          rem_reg;
    logic [15:0]          rem_next;
    logic [23:0]          quo_reg;
    logic [23:0]          quo_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DIV_CNT_W-1:0] cnt_next;
    logic                 busy_reg;
    logic                 busy_next;
    logic [16:0]          rem_sh;
    logic                 fits;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[23]};
        fits      = (rem_sh >= {1'b0, divisor});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = init_rem;
            quo_next  = dividend;
            cnt_next  = DIV_CNT_W'(DIV_STEPS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = 16'(rem_sh - {1'b0, divisor});
            end
            else
            begin
                rem_next = rem_sh[15:0];
            end
            quo_next  = {quo_reg[22:0], fits};
            cnt_next  = cnt_reg - 1'b1;
            busy_next = (cnt_reg != DIV_CNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

/* src/htq_datapath.sv */
// Datapath: configuration registers, height store, dividers and interpolation.
`default_nettype none

module htq_datapath #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [15:0]          cfg_data,
    input  wire htq_pkg::query_t      query_data,
    input  wire htq_pkg::htq_cmd_t    cmd,
    output htq_pkg::htq_status_t      status,
    output htq_pkg::result_t          result_data
);
    import htq_pkg::*;

    localparam int MAXD  = (MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS;
    localparam int IW    = $clog2(MAXD);
    localparam int DW    = IW + 1;
    localparam int DEPTH = MAX_COLUMNS * MAX_ROWS;
    localparam int AW    = $clog2(DEPTH);

    logic [15:0] grid_spacing_reg;
    logic [15:0] height_gain_reg;
    logic [8:0]  map_columns_reg;
    logic [8:0]  map_rows_reg;

    logic [15:0]   sp;
    logic [31:0]   cols_raw;
    logic [31:0]   rows_raw;
    logic [DW-1:0] cnt_eff [2];

    logic signed [23:0] pos_reg [2];
    logic [IW-1:0]      cell_reg [2];
    logic [IW-1:0]      cell_next [2];
    logic [IW-1:0]      nbr_reg [2];
    logic [IW-1:0]      nbr_next [2];
    logic [15:0]        off_reg [2];
    logic [15:0]        off_next [2];
    logic               full_reg [2];
    logic               full_next [2];
    logic [16:0]        frac_reg [2];

    logic [23:0]   div_dividend [2];
    logic [15:0]   div_init [2];
    logic          div_busy [2];
    logic [23:0]   div_quo [2];
    logic [15:0]   div_rem [2];
    logic [DW-1:0] cnt_m1 [2];
    logic [DW-1:0] cell_p1 [2];
    logic          past_end [2];

    logic [AW-1:0]    base0_reg;
    logic [AW-1:0]    base1_reg;
    logic [IW+DW-1:0] base_prod;
    logic             lower;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] raddr;
    logic          wr_en;

    logic [16:0] weight;
    logic [24:0] term;
    logic [23:0] acc_reg;
    logic [23:0] acc_next;
    logic [39:0] scaled;
    logic [23:0] height_reg;
    result_t     out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_spacing_reg <= 16'd512;
            height_gain_reg  <= 16'd410;
            map_columns_reg  <= 9'd256;
            map_rows_reg     <= 9'd256;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_GRID_SPACING: grid_spacing_reg <= cfg_data;
                CFG_HEIGHT_GAIN:  height_gain_reg  <= cfg_data;
                CFG_MAP_COLUMNS:  map_columns_reg  <= cfg_data[8:0];
                CFG_MAP_ROWS:     map_rows_reg     <= cfg_data[8:0];
                default:          grid_spacing_reg <= grid_spacing_reg;
            endcase
        end
    end

    always_comb
    begin
        sp       = (grid_spacing_reg == 16'd0) ? 16'd1 : grid_spacing_reg;
        cols_raw = 32'(map_columns_reg);
        rows_raw = 32'(map_rows_reg);
        if (cols_raw == 32'd0)
        begin
            cols_raw = 32'd1;
        end
        else if (cols_raw > 32'(MAX_COLUMNS))
        begin
            cols_raw = 32'(MAX_COLUMNS);
        end
        if (rows_raw == 32'd0)
        begin
            rows_raw = 32'd1;
        end
        else if (rows_raw > 32'(MAX_ROWS))
        begin
            rows_raw = 32'(MAX_ROWS);
        end
        cnt_eff[0] = cols_raw[DW-1:0];
        cnt_eff[1] = rows_raw[DW-1:0];
    end

    // A negative position divides as zero, which gives cell zero and no offset.
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            div_dividend[a] = (cmd.div_frac || pos_reg[a][23]) ? 24'd0 : pos_reg[a];
            div_init[a]     = (cmd.div_frac && !full_reg[a]) ? off_reg[a] : 16'd0;
            cnt_m1[a]       = cnt_eff[a] - 1'b1;
            past_end[a]     = (div_quo[a] >= {{(24-DW){1'b0}}, cnt_eff[a]});
            cell_next[a]    = past_end[a] ? cnt_m1[a][IW-1:0] : div_quo[a][IW-1:0];
            cell_p1[a]      = {1'b0, cell_next[a]} + 1'b1;
            nbr_next[a]     = (cell_p1[a] >= cnt_eff[a]) ? cnt_m1[a][IW-1:0]
                                                         : cell_p1[a][IW-1:0];
            off_next[a]     = div_rem[a];
            full_next[a]    = past_end[a] && (div_rem[a] == 16'd0);
        end
    end

    htq_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .init_rem  (div_init[0]),
        .dividend  (div_dividend[0]),
        .divisor   (sp),
        .busy      (div_busy[0]),
        .quotient  (div_quo[0]),
        .remainder (div_rem[0])
    );

    htq_div u_div_z (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .init_rem  (div_init[1]),
        .dividend  (div_dividend[1]),
        .divisor   (sp),
        .busy      (div_busy[1]),
        .quotient  (div_quo[1]),
        .remainder (div_rem[1])
    );

    assign status.div_busy = div_busy[0] | div_busy[1];

    // The fraction divide produces 24 quotient bits, so its top 16 quotient bits are the Q0.16 value.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pos_reg[0] <= query_data.pos_x;
            pos_reg[1] <= query_data.pos_z;
        end
        for (int a = 0; a < 2; a++)
        begin
            if (cmd.axis_latch)
            begin
                cell_reg[a] <= cell_next[a];
                nbr_reg[a]  <= nbr_next[a];
                off_reg[a]  <= off_next[a];
                full_reg[a] <= full_next[a];
            end
            if (cmd.frac_latch)
            begin
                frac_reg[a] <= full_reg[a] ? 17'h10000 : {1'b0, div_quo[a][23:8]};
            end
        end
    end

    always_comb
    begin
        if (cmd.base1_latch)
        begin
            base_prod = {{DW{1'b0}}, nbr_reg[1]} * {{IW{1'b0}}, cnt_eff[0]};
        end
        else
        begin
            base_prod = {{DW{1'b0}}, cell_reg[1]} * {{IW{1'b0}}, cnt_eff[0]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.base0_latch)
        begin
            base0_reg <= base_prod[AW-1:0];
        end
        if (cmd.base1_latch)
        begin
            base1_reg <= base_prod[AW-1:0];
        end
    end

    assign lower = (frac_reg[1] >= frac_reg[0]);

    always_comb
    begin
        unique case (cmd.rd_sel)
            SEL_Y0:
            begin
                raddr = base0_reg + {{(AW-IW){1'b0}}, cell_reg[0]};
            end
            SEL_YM:
            begin
                if (lower)
                begin
                    raddr = base1_reg + {{(AW-IW){1'b0}}, cell_reg[0]};
                end
                else
                begin
                    raddr = base0_reg + {{(AW-IW){1'b0}}, nbr_reg[0]};
                end
            end
            SEL_Y2:
            begin
                raddr = base1_reg + {{(AW-IW){1'b0}}, nbr_reg[0]};
            end
            default:
            begin
                raddr = base0_reg;
            end
        endcase
    end

    assign wr_en = cmd.write_sample && (32'(query_data.sample_index) < 32'(DEPTH));

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(query_data.sample_index)] <= query_data.sample_value;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        unique case (cmd.mac_sel)
            SEL_Y0:  weight = lower ? (17'h10000 - frac_reg[1]) : (17'h10000 - frac_reg[0]);
            SEL_YM:  weight = lower ? (frac_reg[1] - frac_reg[0]) : (frac_reg[0] - frac_reg[1]);
            SEL_Y2:  weight = lower ? frac_reg[0] : frac_reg[1];
            default: weight = 17'd0;
        endcase
        term     = {17'd0, rdata_reg} * {8'd0, weight};
        acc_next = (cmd.mac_first ? 24'd0 : acc_reg) + term[23:0];
        scaled   = {16'd0, acc_reg} * {24'd0, height_gain_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mac_en)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.scale)
        begin
            height_reg <= scaled[39:16];
        end
        if (cmd.out_load)
        begin
            out_reg.height         <= height_reg;
            out_reg.upper_triangle <= !lower;
        end
    end

    assign result_data = out_reg;

endmodule

`default_nettype wire

/* src/htq_ctrl.sv */
// Controller state machine that sequences writes and height queries.
`default_nettype none

module htq_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 query_valid,
    input  wire logic                 query_op,
    output logic                      query_ready,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    input  wire htq_pkg::htq_status_t status,
    output htq_pkg::htq_cmd_t         cmd
);
    import htq_pkg::*;

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_Q_START  = 12'b0000_0000_0010,
        ST_Q_WAIT   = 12'b0000_0000_0100,
        ST_F_START  = 12'b0000_0000_1000,
        ST_F_WAIT   = 12'b0000_0001_0000,
        ST_ROW0     = 12'b0000_0010_0000,
        ST_ROW1     = 12'b0000_0100_0000,
        ST_RD_B     = 12'b0000_1000_0000,
        ST_RD_C     = 12'b0001_0000_0000,
        ST_MAC_LAST = 12'b0010_0000_0000,
        ST_SCALE    = 12'b0100_0000_0000,
        ST_DONE     = 12'b1000_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel  = SEL_Y0;
        cmd.mac_sel = SEL_Y0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (query_valid)
                begin
                    if (query_op)
                    begin
                        cmd.capture = 1'b1;
                        state_next  = ST_Q_START;
                    end
                    else
                    begin
                        cmd.write_sample = 1'b1;
                    end
                end
            end
            ST_Q_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_Q_WAIT;
            end
            ST_Q_WAIT:
            begin
                if (!status.div_busy)
                begin
                    cmd.axis_latch = 1'b1;
                    state_next     = ST_F_START;
                end
            end
            ST_F_START:
            begin
                cmd.div_start = 1'b1;
                cmd.div_frac  = 1'b1;
                state_next    = ST_F_WAIT;
            end
            ST_F_WAIT:
            begin
                if (!status.div_busy)
                begin
                    state_next = ST_ROW0;
                end
            end
            ST_ROW0:
            begin
                cmd.frac_latch  = 1'b1;
                cmd.base0_latch = 1'b1;
                state_next      = ST_ROW1;
            end
            ST_ROW1:
            begin
                cmd.base1_latch = 1'b1;
                cmd.rd_en       = 1'b1;
                cmd.rd_sel      = SEL_Y0;
                state_next      = ST_RD_B;
            end
            ST_RD_B:
            begin
                cmd.rd_en     = 1'b1;
                cmd.rd_sel    = SEL_YM;
                cmd.mac_en    = 1'b1;
                cmd.mac_first = 1'b1;
                cmd.mac_sel   = SEL_Y0;
                state_next    = ST_RD_C;
            end
            ST_RD_C:
            begin
                cmd.rd_en   = 1'b1;
                cmd.rd_sel  = SEL_Y2;
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = SEL_YM;
                state_next  = ST_MAC_LAST;
            end
            ST_MAC_LAST:
            begin
                cmd.mac_en  = 1'b1;
                cmd.mac_sel = SEL_Y2;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign query_ready  = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;

endmodule

`default_nettype wire

/* src/heightmap_triangle_height_query_top.sv */
// Top level of the heightmap triangle height query block.
`default_nettype none

// The block stores a byte heightmap of up to MAX_COLUMNS by MAX_ROWS samples and
// answers height queries on the triangle under a world position. A sample write
// takes one beat and gives no result. A query holds the input side while two
// bit-serial divisions by the grid spacing with 24-bit quotients (cell and
// fraction, both axes side by side), three reads of the height store and the
// multiply steps run. A finished result waits in its output register, so the
// next beat is taken while it is still pending. Configuration writes are always
// ready and belong while the block is idle.
module heightmap_triangle_height_query_top #(
    parameter int MAX_COLUMNS = 256,
    parameter int MAX_ROWS    = 256
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [15:0]      cfg_data,
    input  wire logic             query_valid,
    output logic                  query_ready,
    input  wire htq_pkg::query_t  query_data,
    output logic                  result_valid,
    input  wire logic             result_ready,
    output htq_pkg::result_t      result_data
);
    import htq_pkg::*;

    htq_cmd_t    cmd;
    htq_status_t status;

    assign cfg_ready = 1'b1;

    htq_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .query_valid  (query_valid),
        .query_op     (query_data.op),
        .query_ready  (query_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .status       (status),
        .cmd          (cmd)
    );

    htq_datapath #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .query_data  (query_data),
        .cmd         (cmd),
        .status      (status),
        .result_data (result_data)
    );

endmodule

`default_nettype wire
